>>> rtl/triangle_vertex_normal_accumulator_core_defines.svh
// Assertion macros for the vertex normal accumulator.
// Used by the controller and the top level; no other dependency.
`ifndef TRIANGLE_VERTEX_NORMAL_ACCUMULATOR_CORE_DEFINES_SVH
`define TRIANGLE_VERTEX_NORMAL_ACCUMULATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TVNA_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("label");
`define TVNA_ASSERT_NEXT(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("label");
`else
`define TVNA_ASSERT(label, clk, rstn, prop)
`define TVNA_ASSERT_NEXT(label, clk, rstn, pre, post)
`endif
`endif

>>> rtl/tvna_pkg.sv
// Shared types, codes and helpers for the vertex normal accumulator.
// No dependencies.
package tvna_pkg;
  localparam int unsigned MaxVertices = 256;
  localparam int unsigned AccW = 48;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0, FUNC_TRI = 2'd1, FUNC_READ = 2'd2, FUNC_CLEAR = 2'd3
  } func_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         index_a;
    logic [7:0]         index_b;
    logic [7:0]         index_c;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] normal_x;
    logic signed [47:0] normal_y;
    logic signed [47:0] normal_z;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RDA, ST_RDB, ST_RDC, ST_MUL, ST_SUB, ST_CROSS,
    ST_ACC_A, ST_RDACC_B, ST_ACC_B, ST_RDACC_C, ST_ACC_C, ST_RD, ST_OUT, ST_CLRMEM
  } state_e;

  // Memory port selector used by the datapath.
  typedef enum logic [1:0] {SEL_A, SEL_B, SEL_C} sel_e;

  typedef struct packed {
    logic  pos_wr;      // write position of index_a
    logic  pos_rd;      // read position at sel
    logic  latch_a;
    logic  latch_b;
    logic  latch_c;
    logic  mul;         // form products
    logic  sub;         // form cross product
    logic  acc_rd;      // read accumulator at sel
    logic  acc_wr;      // write saturated sum at sel (uses last read)
    logic  acc_clr;     // write zero at clr address
    logic  clr_sweep;   // clear address from sweep counter
    logic  out_load;    // capture read data (or zero) into output
    sel_e  sel;
  } cmd_t;

  function automatic logic signed [47:0] sat_add(input logic signed [47:0] acc,
                                                 input logic signed [34:0] d);
    logic signed [48:0] s;
    s = 49'(acc) + 49'(d);
    if (s > 49'sh0_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (s < -49'sh0_8000_0000_0000) return 48'sh8000_0000_0000;
    return s[47:0];
  endfunction
endpackage

>>> rtl/triangle_vertex_normal_accumulator_core.sv
// Top level of the area-weighted vertex normal accumulator.
// Depends on tvna_pkg, tvna_ctrl, tvna_datapath and the macro header.
//
// After reset the block runs a clearing pass over every entry of the normal
// store, during which in_ready_o is low. Loads and clears act in the cycle
// of their transfer, so the next item can be accepted in the following
// cycle. A read passes through ST_RD and ST_OUT before it raises
// out_valid_o, and the next item waits until the result is transferred; it
// can be accepted in the cycle after that. A triangle occupies the block
// from its transfer to the next accepted item: three position reads on the
// single-port position memory, a product stage, a subtract stage, and a
// read-modify-write of each of the three accumulators on the single-port
// normal memory, done strictly in order A, B, C so a repeated index
// accumulates once per occurrence. Triangles with any out-of-range index are
// dropped in ST_RDA; a read of an out-of-range index returns zeros.
`include "triangle_vertex_normal_accumulator_core_defines.svh"
module triangle_vertex_normal_accumulator_core #(
  parameter int unsigned MAX_VERTICES = tvna_pkg::MaxVertices
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tvna_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tvna_pkg::out_item_t out_data_o
);
  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  tvna_pkg::cmd_t cmd;
  tvna_pkg::in_item_t item;
  logic [AW-1:0] sweep;
  logic a_ok;

  tvna_ctrl #(.MaxVertices(MAX_VERTICES)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .item_i(in_data_i), .item_o(item), .sweep_o(sweep), .a_ok_o(a_ok), .cmd_o(cmd)
  );

  tvna_datapath #(.MaxVertices(MAX_VERTICES)) u_dp (
    .clk_i, .cmd_i(cmd), .item_i(item), .sweep_i(sweep), .a_ok_i(a_ok),
    .out_o(out_data_o)
  );

  `TVNA_ASSERT(a_no_rd_wr, clk_i, rst_ni, !(cmd.acc_rd && cmd.acc_wr))
  `TVNA_ASSERT_NEXT(a_hold_out, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_data_o))
  `TVNA_ASSERT(a_ready_no_out, clk_i, rst_ni, !(in_ready_o && out_valid_o))
endmodule

>>> rtl/tvna_datapath.sv
// Datapath: position and accumulator memories, cross product, saturation.
// Depends on tvna_pkg.
module tvna_datapath #(
  parameter int unsigned MaxVertices = tvna_pkg::MaxVertices,
  localparam int unsigned AW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1
) (
  input  logic                clk_i,
  input  tvna_pkg::cmd_t      cmd_i,
  input  tvna_pkg::in_item_t  item_i,
  input  logic [AW-1:0]       sweep_i,
  input  logic                a_ok_i,
  output tvna_pkg::out_item_t out_o
);
  logic signed [47:0] pos_mem [MaxVertices];
  logic signed [143:0] acc_mem [MaxVertices];
  logic signed [47:0] pos_rd_q;
  logic signed [143:0] acc_rd_q;
  logic signed [15:0] ax_q, ay_q, az_q;
  logic signed [16:0] ux_q, uy_q, uz_q, wx_q, wy_q, wz_q;
  logic signed [33:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [34:0] nx_q, ny_q, nz_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0] sel_idx;

  always_comb begin
    case (cmd_i.sel)
      tvna_pkg::SEL_A: sel_idx = item_i.index_a;
      tvna_pkg::SEL_B: sel_idx = item_i.index_b;
      tvna_pkg::SEL_C: sel_idx = item_i.index_c;
      default:         sel_idx = item_i.index_a;
    endcase
    rd_addr = AW'(sel_idx);
    wr_addr = cmd_i.clr_sweep ? sweep_i : rd_addr;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_wr) pos_mem[AW'(item_i.index_a)] <= {item_i.pos_x, item_i.pos_y, item_i.pos_z};
    if (cmd_i.pos_rd) pos_rd_q <= pos_mem[rd_addr];
    if (cmd_i.acc_clr) acc_mem[wr_addr] <= '0;
    else if (cmd_i.acc_wr)
      acc_mem[wr_addr] <= {tvna_pkg::sat_add(acc_rd_q[143:96], nx_q),
                           tvna_pkg::sat_add(acc_rd_q[95:48], ny_q),
                           tvna_pkg::sat_add(acc_rd_q[47:0], nz_q)};
    if (cmd_i.acc_rd) acc_rd_q <= acc_mem[rd_addr];
  end

  // Differences are taken from the registered read of the previous step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_a) begin
      ax_q <= pos_rd_q[47:32]; ay_q <= pos_rd_q[31:16]; az_q <= pos_rd_q[15:0];
    end
    if (cmd_i.latch_b) begin
      ux_q <= 17'($signed(pos_rd_q[47:32])) - 17'(ax_q);
      uy_q <= 17'($signed(pos_rd_q[31:16])) - 17'(ay_q);
      uz_q <= 17'($signed(pos_rd_q[15:0])) - 17'(az_q);
    end
    if (cmd_i.latch_c) begin
      wx_q <= 17'($signed(pos_rd_q[47:32])) - 17'(ax_q);
      wy_q <= 17'($signed(pos_rd_q[31:16])) - 17'(ay_q);
      wz_q <= 17'($signed(pos_rd_q[15:0])) - 17'(az_q);
    end
    if (cmd_i.mul) begin
      p0_q <= uy_q * wz_q; p1_q <= uz_q * wy_q;
      p2_q <= uz_q * wx_q; p3_q <= ux_q * wz_q;
      p4_q <= ux_q * wy_q; p5_q <= uy_q * wx_q;
    end
    if (cmd_i.sub) begin
      nx_q <= 35'(p0_q) - 35'(p1_q);
      ny_q <= 35'(p2_q) - 35'(p3_q);
      nz_q <= 35'(p4_q) - 35'(p5_q);
    end
    if (cmd_i.out_load) begin
      if (a_ok_i) out_o <= acc_rd_q;
      else        out_o <= '0;
    end
  end
endmodule

>>> rtl/tvna_ctrl.sv
// Controller state machine: sequences memory accesses and handshakes.
// Depends on tvna_pkg and the assertion macro header.
`include "triangle_vertex_normal_accumulator_core_defines.svh"
module tvna_ctrl #(
  parameter int unsigned MaxVertices = tvna_pkg::MaxVertices,
  localparam int unsigned AW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  tvna_pkg::in_item_t item_i,
  output tvna_pkg::in_item_t item_o,
  output logic [AW-1:0]      sweep_o,
  output logic               a_ok_o,
  output tvna_pkg::cmd_t     cmd_o
);
  tvna_pkg::state_e state_q, state_d;
  tvna_pkg::in_item_t item_q;
  logic [AW-1:0] sweep_q;
  logic out_valid_q, out_valid_d;
  logic a_ok, b_ok, c_ok, take;

  assign a_ok = 32'(item_i.index_a) < MaxVertices;
  assign b_ok = 32'(item_q.index_b) < MaxVertices;
  assign c_ok = 32'(item_q.index_c) < MaxVertices;
  assign in_ready_o = (state_q == tvna_pkg::ST_IDLE) && !out_valid_q;
  assign take = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign sweep_o = sweep_q;
  assign a_ok_o = 32'(item_q.index_a) < MaxVertices;

  // Loads and clears act straight off the input; others use the held item.
  assign item_o = (state_q == tvna_pkg::ST_IDLE) ? item_i : item_q;

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      tvna_pkg::ST_CLRMEM:
        if (32'(sweep_q) == MaxVertices - 1) state_d = tvna_pkg::ST_IDLE;
      tvna_pkg::ST_IDLE:
        if (take) begin
          case (tvna_pkg::func_e'(item_i.func))
            tvna_pkg::FUNC_TRI:  state_d = tvna_pkg::ST_RDA;
            tvna_pkg::FUNC_READ: state_d = tvna_pkg::ST_RD;
            default:             state_d = tvna_pkg::ST_IDLE;
          endcase
        end
      tvna_pkg::ST_RDA: state_d = (a_ok_o && b_ok && c_ok) ? tvna_pkg::ST_RDB
                                                          : tvna_pkg::ST_IDLE;
      tvna_pkg::ST_RDB:     state_d = tvna_pkg::ST_RDC;
      tvna_pkg::ST_RDC:     state_d = tvna_pkg::ST_MUL;
      tvna_pkg::ST_MUL:     state_d = tvna_pkg::ST_SUB;
      tvna_pkg::ST_SUB:     state_d = tvna_pkg::ST_CROSS;
      tvna_pkg::ST_CROSS:   state_d = tvna_pkg::ST_ACC_A;
      tvna_pkg::ST_ACC_A:   state_d = tvna_pkg::ST_RDACC_B;
      tvna_pkg::ST_RDACC_B: state_d = tvna_pkg::ST_ACC_B;
      tvna_pkg::ST_ACC_B:   state_d = tvna_pkg::ST_RDACC_C;
      tvna_pkg::ST_RDACC_C: state_d = tvna_pkg::ST_ACC_C;
      tvna_pkg::ST_ACC_C:   state_d = tvna_pkg::ST_IDLE;
      tvna_pkg::ST_RD:      state_d = tvna_pkg::ST_OUT;
      tvna_pkg::ST_OUT: begin
        state_d = tvna_pkg::ST_IDLE;
        out_valid_d = 1'b1;
      end
      default: state_d = tvna_pkg::ST_IDLE;
    endcase
  end

  // Accumulator updates are read-then-write, one vertex at a time in order
  // A, B, C. Each read comes in the state after the previous write, so a
  // repeated index sees the freshly written value.
  always_comb begin
    cmd_o = '0;
    cmd_o.sel = tvna_pkg::SEL_A;
    case (state_q)
      tvna_pkg::ST_CLRMEM: begin
        cmd_o.acc_clr = 1'b1;
        cmd_o.clr_sweep = 1'b1;
      end
      tvna_pkg::ST_IDLE: begin
        if (take && a_ok) begin
          cmd_o.pos_wr = (item_i.func == tvna_pkg::FUNC_LOAD);
          cmd_o.acc_clr = (item_i.func == tvna_pkg::FUNC_CLEAR);
        end
      end
      tvna_pkg::ST_RDA: begin cmd_o.pos_rd = 1'b1; cmd_o.sel = tvna_pkg::SEL_A; end
      tvna_pkg::ST_RDB: begin
        cmd_o.pos_rd = 1'b1; cmd_o.sel = tvna_pkg::SEL_B; cmd_o.latch_a = 1'b1;
      end
      tvna_pkg::ST_RDC: begin
        cmd_o.pos_rd = 1'b1; cmd_o.sel = tvna_pkg::SEL_C; cmd_o.latch_b = 1'b1;
      end
      tvna_pkg::ST_MUL: begin
        cmd_o.latch_c = 1'b1;
      end
      tvna_pkg::ST_SUB: begin
        cmd_o.mul = 1'b1;
        cmd_o.acc_rd = 1'b1; cmd_o.sel = tvna_pkg::SEL_A;
      end
      tvna_pkg::ST_CROSS: begin
        cmd_o.sub = 1'b1;
      end
      tvna_pkg::ST_ACC_A: begin
        cmd_o.acc_wr = 1'b1; cmd_o.sel = tvna_pkg::SEL_A;
      end
      tvna_pkg::ST_RDACC_B: begin
        cmd_o.acc_rd = 1'b1; cmd_o.sel = tvna_pkg::SEL_B;
      end
      tvna_pkg::ST_ACC_B: begin
        cmd_o.acc_wr = 1'b1; cmd_o.sel = tvna_pkg::SEL_B;
      end
      tvna_pkg::ST_RDACC_C: begin
        cmd_o.acc_rd = 1'b1; cmd_o.sel = tvna_pkg::SEL_C;
      end
      tvna_pkg::ST_ACC_C: begin
        cmd_o.acc_wr = 1'b1; cmd_o.sel = tvna_pkg::SEL_C;
      end
      tvna_pkg::ST_RD: begin cmd_o.acc_rd = 1'b1; cmd_o.sel = tvna_pkg::SEL_A; end
      tvna_pkg::ST_OUT: cmd_o.out_load = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tvna_pkg::ST_CLRMEM;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == tvna_pkg::ST_CLRMEM) sweep_q <= sweep_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) item_q <= item_i;
  end

  `TVNA_ASSERT(a_out_only_idle, clk_i, rst_ni, !(out_valid_q && state_q != tvna_pkg::ST_IDLE))
  `TVNA_ASSERT_NEXT(a_out_after_rd, clk_i, rst_ni, state_q == tvna_pkg::ST_OUT, out_valid_q)
  `TVNA_ASSERT(a_take_idle, clk_i, rst_ni, !(take && state_q != tvna_pkg::ST_IDLE))
endmodule

>>> test/tvna_checker.sv
// Checker for the vertex normal accumulator: watches both channels, predicts reads.
// Depends on tvna_pkg only.
`timescale 1ns / 1ps
module tvna_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  tvna_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  tvna_pkg::out_item_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  logic signed [15:0]  vert_pos [256][3];
  logic signed [47:0]  norm_acc [256][3];
  tvna_pkg::out_item_t normal_q [$];

  function automatic logic signed [47:0] clamp_add(logic signed [47:0] acc,
                                                   logic signed [63:0] d);
    logic signed [63:0] s;
    s = 64'(acc) + d;
    if (s > 64'sh7FFF_FFFF_FFFF) s = 64'sh7FFF_FFFF_FFFF;
    if (s < -64'sh8000_0000_0000) s = -64'sh8000_0000_0000;
    return s[47:0];
  endfunction

  task automatic apply_item(tvna_pkg::in_item_t it);
    logic signed [63:0] u [3];
    logic signed [63:0] w [3];
    logic signed [63:0] n [3];
    int idx [3];
    tvna_pkg::out_item_t r;
    idx[0] = int'(it.index_a); idx[1] = int'(it.index_b); idx[2] = int'(it.index_c);
    case (tvna_pkg::func_e'(it.func))
      tvna_pkg::FUNC_LOAD: begin
        vert_pos[idx[0]][0] = it.pos_x;
        vert_pos[idx[0]][1] = it.pos_y;
        vert_pos[idx[0]][2] = it.pos_z;
      end
      tvna_pkg::FUNC_TRI: begin
        for (int k = 0; k < 3; k++) begin
          u[k] = 64'(vert_pos[idx[1]][k]) - 64'(vert_pos[idx[0]][k]);
          w[k] = 64'(vert_pos[idx[2]][k]) - 64'(vert_pos[idx[0]][k]);
        end
        n[0] = u[1] * w[2] - u[2] * w[1];
        n[1] = u[2] * w[0] - u[0] * w[2];
        n[2] = u[0] * w[1] - u[1] * w[0];
        for (int v = 0; v < 3; v++)
          for (int k = 0; k < 3; k++)
            norm_acc[idx[v]][k] = clamp_add(norm_acc[idx[v]][k], n[k]);
      end
      tvna_pkg::FUNC_READ: begin
        r.normal_x = norm_acc[idx[0]][0];
        r.normal_y = norm_acc[idx[0]][1];
        r.normal_z = norm_acc[idx[0]][2];
        normal_q.push_back(r);
      end
      default: begin
        for (int k = 0; k < 3; k++) norm_acc[idx[0]][k] = '0;
      end
    endcase
  endtask

  initial begin
    fail_count_o = 0;
    for (int i = 0; i < 256; i++)
      for (int k = 0; k < 3; k++) begin
        norm_acc[i][k] = '0;
        vert_pos[i][k] = '0;
      end
  end

  assign pending_o = normal_q.size();

  always @(posedge clk_i) begin
    tvna_pkg::out_item_t exp_r;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) apply_item(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (normal_q.size() == 0) begin
          $error("unexpected normal transfer");
          fail_count_o++;
        end else begin
          exp_r = normal_q.pop_front();
          if (out_data_i.normal_x !== exp_r.normal_x) begin
            $error("normal_x expected %0d actual %0d", exp_r.normal_x, out_data_i.normal_x);
            fail_count_o++;
          end
          if (out_data_i.normal_y !== exp_r.normal_y) begin
            $error("normal_y expected %0d actual %0d", exp_r.normal_y, out_data_i.normal_y);
            fail_count_o++;
          end
          if (out_data_i.normal_z !== exp_r.normal_z) begin
            $error("normal_z expected %0d actual %0d", exp_r.normal_z, out_data_i.normal_z);
            fail_count_o++;
          end
        end
      end
    end
  end
endmodule

>>> test/tb.sv
// Testbench top for the vertex normal accumulator: stimulus, idling and verdict.
// Depends on tvna_pkg, the accumulator core and tvna_checker.
`timescale 1ns / 1ps
module tb;
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  tvna_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  tvna_pkg::out_item_t out_data;
  int                  fail_count;
  int                  pending;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  bit                  hold_off = 1'b0;
  bit                  loaded [256];
  int                  loaded_list [$];
  longint              cycle_count = 0;

  always #4 clk = ~clk;

  triangle_vertex_normal_accumulator_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  tvna_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver: random stall unless a long hold-off is in force.
  always @(posedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Guard the whole run with a generous cycle limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one item, hold it until the transfer, then optionally idle.
  task automatic send(tvna_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (it.func == tvna_pkg::FUNC_LOAD && !loaded[it.index_a]) begin
      loaded[it.index_a] = 1'b1;
      loaded_list.push_back(int'(it.index_a));
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  function automatic tvna_pkg::in_item_t mk(tvna_pkg::func_e f, int a, int b, int c,
                                            logic [15:0] x, logic [15:0] y, logic [15:0] z);
    tvna_pkg::in_item_t it;
    it.func = f; it.index_a = 8'(a); it.index_b = 8'(b); it.index_c = 8'(c);
    it.pos_x = x; it.pos_y = y; it.pos_z = z;
    return it;
  endfunction

  // Pick a vertex already loaded so no triangle touches an unwritten position.
  function automatic int pick_vertex();
    return loaded_list[$urandom_range(loaded_list.size() - 1)];
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic tvna_pkg::in_item_t rand_item();
    tvna_pkg::in_item_t it;
    int sel;
    sel = $urandom_range(99);
    it = mk(tvna_pkg::FUNC_LOAD, $urandom_range(255), $urandom_range(255),
            $urandom_range(255), rand_coord(), rand_coord(), rand_coord());
    if (sel < 25) return it;
    if (sel < 65) begin
      it.func = tvna_pkg::FUNC_TRI;
      it.index_a = 8'(pick_vertex());
      it.index_b = 8'(pick_vertex());
      it.index_c = 8'(pick_vertex());
      if ($urandom_range(9) == 0) it.index_b = it.index_a;
    end else if (sel < 92) begin
      it.func = tvna_pkg::FUNC_READ;
      if ($urandom_range(1)) it.index_a = 8'(pick_vertex());
    end else begin
      it.func = tvna_pkg::FUNC_CLEAR;
    end
    return it;
  endfunction

  initial begin
    int phase_pct [4][2];
    phase_pct = '{'{0, 0}, '{71, 0}, '{0, 71}, '{35, 35}};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme vertices, repeats, degenerate, clears.
    send(mk(tvna_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0));
    send(mk(tvna_pkg::FUNC_LOAD, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000));
    send(mk(tvna_pkg::FUNC_LOAD, 1, 0, 0, 16'h7FFF, 16'h8000, 16'h7FFF));
    send(mk(tvna_pkg::FUNC_LOAD, 2, 0, 0, 16'h8000, 16'h7FFF, 16'h7FFF));
    send(mk(tvna_pkg::FUNC_LOAD, 255, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send(mk(tvna_pkg::FUNC_TRI, 0, 1, 2, 0, 0, 0));
    send(mk(tvna_pkg::FUNC_TRI, 0, 0, 255, 0, 0, 0));
    send(mk(tvna_pkg::FUNC_TRI, 255, 255, 255, 0, 0, 0));
    send(mk(tvna_pkg::FUNC_TRI, 2, 1, 255, 0, 0, 0));
    for (int i = 0; i < 6; i++) send(mk(tvna_pkg::FUNC_TRI, 0, 1, 2, 0, 0, 0));
    send(mk(tvna_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0));
    send(mk(tvna_pkg::FUNC_READ, 1, 0, 0, 0, 0, 0));
    send(mk(tvna_pkg::FUNC_READ, 255, 0, 0, 0, 0, 0));
    send(mk(tvna_pkg::FUNC_CLEAR, 1, 0, 0, 0, 0, 0));
    send(mk(tvna_pkg::FUNC_READ, 1, 0, 0, 0, 0, 0));
    send(mk(tvna_pkg::FUNC_CLEAR, 255, 0, 0, 0, 0, 0));
    send(mk(tvna_pkg::FUNC_READ, 2, 0, 0, 0, 0, 0));

    // Random phases; partway through the first phase the receiver is held off.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = phase_pct[ph][0];
      recv_stall_pct = phase_pct[ph][1];
      for (int n = 0; n < 185; n++) begin
        if (ph == 0 && n == 100) begin
          fork
            begin
              hold_off = 1'b1;
              repeat (300) @(posedge clk);
              hold_off = 1'b0;
            end
          join_none
        end
        send(rand_item());
      end
    end
    in_valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
